// ===== rtl/tlfk_pkg.sv =====
`timescale 1ns / 1ps
package tlfk_pkg;

  // Field widths.
  localparam int ANG_W   = 20;
  localparam int LEN_W   = 31;
  localparam int POS_W   = 32;
  localparam int CFG_W   = 32;
  localparam int CFG_IW  = 3;
  localparam int WIDE_W  = 36;  // angle in Q30 before reduction
  localparam int Z_W     = 33;  // rotation datapath, Q30 with headroom
  localparam int PROD_W  = 65;  // length times trig value
  localparam int SCL_W   = 35;  // scaled offset, Q16.16 with headroom
  localparam int ELB_W   = 36;  // unsaturated elbow
  localparam int END_W   = 37;  // unsaturated end point

  // Pipeline depths around the rotation stages.
  localparam int REDUCE_STAGES   = 3;
  localparam int POSITION_STAGES = 4;
  localparam int MAX_STEPS       = 24;

  // Angle constants in Q30.
  localparam logic signed [WIDE_W-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [WIDE_W-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [WIDE_W-1:0] Q30_3PI     = 36'sd10119778278;
  localparam logic signed [WIDE_W-1:0] Q30_5PI     = 36'sd16866297130;
  localparam logic signed [Z_W-1:0]    CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [PROD_W-1:0] ROUND_HALF  = 65'sd536870912;

  // Configuration register indexes.
  typedef enum logic [CFG_IW-1:0] {
    REG_LINK1_LENGTH = 3'd0,
    REG_LINK2_LENGTH = 3'd1,
    REG_ORIGIN_X     = 3'd2,
    REG_ORIGIN_Y     = 3'd3,
    REG_JOINT1_MIN   = 3'd4,
    REG_JOINT1_MAX   = 3'd5,
    REG_JOINT2_MIN   = 3'd6,
    REG_JOINT2_MAX   = 3'd7
  } cfg_idx_t;

  // One rotation lane: cosine, sine and residual angle.
  typedef struct packed {
    logic signed [Z_W-1:0] x;
    logic signed [Z_W-1:0] y;
    logic signed [Z_W-1:0] z;
  } rot_t;

  // Control that travels with each request down the pipeline.
  typedef struct packed {
    logic vld;
    logic ok;
    logic neg_a;
    logic neg_b;
  } ctl_t;

  // Arctangent of 2^-i in Q30.
  function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
    logic signed [Z_W-1:0] a;
    case (idx)
      0:  a = 33'sd843314857;
      1:  a = 33'sd497837829;
      2:  a = 33'sd263043837;
      3:  a = 33'sd133525159;
      4:  a = 33'sd67021687;
      5:  a = 33'sd33543516;
      6:  a = 33'sd16775851;
      7:  a = 33'sd8388437;
      8:  a = 33'sd4194283;
      9:  a = 33'sd2097149;
      10: a = 33'sd1048576;
      11: a = 33'sd524288;
      12: a = 33'sd262144;
      13: a = 33'sd131072;
      14: a = 33'sd65536;
      15: a = 33'sd32768;
      16: a = 33'sd16384;
      17: a = 33'sd8192;
      18: a = 33'sd4096;
      19: a = 33'sd2048;
      20: a = 33'sd1024;
      21: a = 33'sd512;
      22: a = 33'sd256;
      23: a = 33'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Number of turns to take off so the angle lands in [-pi, pi).
  function automatic logic signed [2:0] wrap_count(input logic signed [WIDE_W-1:0] v);
    logic signed [2:0] k;
    if (v >= Q30_5PI) k = 3'sd3;
    else if (v >= Q30_3PI) k = 3'sd2;
    else if (v >= Q30_PI) k = 3'sd1;
    else if (v < -Q30_5PI) k = -3'sd3;
    else if (v < -Q30_3PI) k = -3'sd2;
    else if (v < -Q30_PI) k = -3'sd1;
    else k = 3'sd0;
    return k;
  endfunction

  // Whole turns in Q30.
  function automatic logic signed [WIDE_W-1:0] turns_q30(input logic signed [2:0] k);
    logic signed [WIDE_W-1:0] t;
    case (k)
      3'sd3:  t = 36'sd20239556556;
      3'sd2:  t = 36'sd13493037704;
      3'sd1:  t = 36'sd6746518852;
      -3'sd1: t = -36'sd6746518852;
      -3'sd2: t = -36'sd13493037704;
      -3'sd3: t = -36'sd20239556556;
      default: t = '0;
    endcase
    return t;
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic logic [POS_W-1:0] sat32(input logic signed [END_W-1:0] v);
    logic [POS_W-1:0] r;
    if (v > 37'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -37'sd2147483648) r = 32'h8000_0000;
    else r = v[POS_W-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/tlfk_angle_reduce.sv =====
`timescale 1ns / 1ps
module tlfk_angle_reduce (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           req_vld,
  input  logic                           cfg_ok,
  input  logic signed [tlfk_pkg::ANG_W-1:0] angle_one,
  input  logic signed [tlfk_pkg::ANG_W-1:0] angle_two,
  output tlfk_pkg::ctl_t                 ctl,
  output tlfk_pkg::rot_t                 lane_a,
  output tlfk_pkg::rot_t                 lane_b
);

  logic signed [tlfk_pkg::ANG_W:0]    sum_w;
  logic signed [tlfk_pkg::WIDE_W-1:0] va_w, vb_w;

  logic                               s1_vld_r, s1_ok_r;
  logic signed [tlfk_pkg::WIDE_W-1:0] s1_va_r, s1_vb_r;
  logic signed [2:0]                  s1_ka_r, s1_kb_r;

  logic                               s2_vld_r, s2_ok_r;
  logic signed [tlfk_pkg::WIDE_W-1:0] ra_w, rb_w;
  logic signed [tlfk_pkg::Z_W-1:0]    s2_ra_r, s2_rb_r;

  tlfk_pkg::ctl_t ctl_nxt, ctl_r;
  tlfk_pkg::rot_t lane_a_nxt, lane_b_nxt, lane_a_r, lane_b_r;

  // Joint sum and widening to Q30.
  assign sum_w = {angle_one[tlfk_pkg::ANG_W-1], angle_one}
               + {angle_two[tlfk_pkg::ANG_W-1], angle_two};
  assign va_w  = {{2{angle_one[tlfk_pkg::ANG_W-1]}}, angle_one, 14'd0};
  assign vb_w  = {sum_w[tlfk_pkg::ANG_W], sum_w, 14'd0};

  // Stage one: pick the number of whole turns.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= req_vld;
    end
    s1_ok_r <= cfg_ok;
    s1_va_r <= va_w;
    s1_vb_r <= vb_w;
    s1_ka_r <= tlfk_pkg::wrap_count(va_w);
    s1_kb_r <= tlfk_pkg::wrap_count(vb_w);
  end

  // Stage two: remove the turns, leaving [-pi, pi).
  assign ra_w = s1_va_r - tlfk_pkg::turns_q30(s1_ka_r);
  assign rb_w = s1_vb_r - tlfk_pkg::turns_q30(s1_kb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_ok_r <= s1_ok_r;
    s2_ra_r <= ra_w[tlfk_pkg::Z_W-1:0];
    s2_rb_r <= rb_w[tlfk_pkg::Z_W-1:0];
  end

  // Stage three: fold into [-pi/2, pi/2] and seed the rotation.
  always_comb begin
    ctl_nxt.vld   = s2_vld_r;
    ctl_nxt.ok    = s2_ok_r;
    ctl_nxt.neg_a = 1'b0;
    ctl_nxt.neg_b = 1'b0;
    lane_a_nxt.x  = tlfk_pkg::CORDIC_GAIN;
    lane_a_nxt.y  = '0;
    lane_a_nxt.z  = s2_ra_r;
    lane_b_nxt.x  = tlfk_pkg::CORDIC_GAIN;
    lane_b_nxt.y  = '0;
    lane_b_nxt.z  = s2_rb_r;
    if (s2_ra_r > tlfk_pkg::Z_W'(tlfk_pkg::Q30_HALF_PI)) begin
      lane_a_nxt.z  = s2_ra_r - tlfk_pkg::Z_W'(tlfk_pkg::Q30_PI);
      ctl_nxt.neg_a = 1'b1;
    end else if (s2_ra_r < -tlfk_pkg::Z_W'(tlfk_pkg::Q30_HALF_PI)) begin
      lane_a_nxt.z  = s2_ra_r + tlfk_pkg::Z_W'(tlfk_pkg::Q30_PI);
      ctl_nxt.neg_a = 1'b1;
    end
    if (s2_rb_r > tlfk_pkg::Z_W'(tlfk_pkg::Q30_HALF_PI)) begin
      lane_b_nxt.z  = s2_rb_r - tlfk_pkg::Z_W'(tlfk_pkg::Q30_PI);
      ctl_nxt.neg_b = 1'b1;
    end else if (s2_rb_r < -tlfk_pkg::Z_W'(tlfk_pkg::Q30_HALF_PI)) begin
      lane_b_nxt.z  = s2_rb_r + tlfk_pkg::Z_W'(tlfk_pkg::Q30_PI);
      ctl_nxt.neg_b = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else begin
      ctl_r.vld <= ctl_nxt.vld;
    end
    ctl_r.ok    <= ctl_nxt.ok;
    ctl_r.neg_a <= ctl_nxt.neg_a;
    ctl_r.neg_b <= ctl_nxt.neg_b;
    lane_a_r    <= lane_a_nxt;
    lane_b_r    <= lane_b_nxt;
  end

  assign ctl    = ctl_r;
  assign lane_a = lane_a_r;
  assign lane_b = lane_b_r;

endmodule

// ===== rtl/tlfk_cordic.sv =====
`timescale 1ns / 1ps
module tlfk_cordic #(
  parameter int STEPS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tlfk_pkg::ctl_t ctl_in,
  input  tlfk_pkg::rot_t lane_a_in,
  input  tlfk_pkg::rot_t lane_b_in,
  output tlfk_pkg::ctl_t ctl_out,
  output tlfk_pkg::rot_t lane_a_out,
  output tlfk_pkg::rot_t lane_b_out
);

  tlfk_pkg::ctl_t ctl_c    [STEPS+1];
  tlfk_pkg::rot_t lane_a_c [STEPS+1];
  tlfk_pkg::rot_t lane_b_c [STEPS+1];

  assign ctl_c[0]    = ctl_in;
  assign lane_a_c[0] = lane_a_in;
  assign lane_b_c[0] = lane_b_in;

  // One registered rotation step per iteration, both lanes side by side.
  for (genvar g = 0; g < STEPS; g++) begin : g_step
    tlfk_pkg::rot_t a_nxt, b_nxt, a_r, b_r;
    tlfk_pkg::ctl_t ctl_r;

    always_comb begin
      if (!lane_a_c[g].z[tlfk_pkg::Z_W-1]) begin
        a_nxt.x = lane_a_c[g].x - (lane_a_c[g].y >>> g);
        a_nxt.y = lane_a_c[g].y + (lane_a_c[g].x >>> g);
        a_nxt.z = lane_a_c[g].z - tlfk_pkg::atan_q30(g);
      end else begin
        a_nxt.x = lane_a_c[g].x + (lane_a_c[g].y >>> g);
        a_nxt.y = lane_a_c[g].y - (lane_a_c[g].x >>> g);
        a_nxt.z = lane_a_c[g].z + tlfk_pkg::atan_q30(g);
      end
      if (!lane_b_c[g].z[tlfk_pkg::Z_W-1]) begin
        b_nxt.x = lane_b_c[g].x - (lane_b_c[g].y >>> g);
        b_nxt.y = lane_b_c[g].y + (lane_b_c[g].x >>> g);
        b_nxt.z = lane_b_c[g].z - tlfk_pkg::atan_q30(g);
      end else begin
        b_nxt.x = lane_b_c[g].x + (lane_b_c[g].y >>> g);
        b_nxt.y = lane_b_c[g].y - (lane_b_c[g].x >>> g);
        b_nxt.z = lane_b_c[g].z + tlfk_pkg::atan_q30(g);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r.vld <= 1'b0;
      end else begin
        ctl_r.vld <= ctl_c[g].vld;
      end
      ctl_r.ok    <= ctl_c[g].ok;
      ctl_r.neg_a <= ctl_c[g].neg_a;
      ctl_r.neg_b <= ctl_c[g].neg_b;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
    end

    assign ctl_c[g+1]    = ctl_r;
    assign lane_a_c[g+1] = a_r;
    assign lane_b_c[g+1] = b_r;
  end

  assign ctl_out    = ctl_c[STEPS];
  assign lane_a_out = lane_a_c[STEPS];
  assign lane_b_out = lane_b_c[STEPS];

endmodule

// ===== rtl/tlfk_position.sv =====
`timescale 1ns / 1ps
module tlfk_position (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tlfk_pkg::ctl_t                  ctl,
  input  tlfk_pkg::rot_t                  lane_a,
  input  tlfk_pkg::rot_t                  lane_b,
  input  logic [tlfk_pkg::LEN_W-1:0]      link1_length,
  input  logic [tlfk_pkg::LEN_W-1:0]      link2_length,
  input  logic signed [tlfk_pkg::POS_W-1:0] origin_x,
  input  logic signed [tlfk_pkg::POS_W-1:0] origin_y,
  output logic                            res_vld,
  output logic [tlfk_pkg::POS_W-1:0]      elbow_x,
  output logic [tlfk_pkg::POS_W-1:0]      elbow_y,
  output logic [tlfk_pkg::POS_W-1:0]      end_x,
  output logic [tlfk_pkg::POS_W-1:0]      end_y,
  output logic                            pose_valid
);

  logic                              p1_vld_r, p1_ok_r;
  logic signed [tlfk_pkg::Z_W-1:0]   p1_c1_r, p1_s1_r, p1_c2_r, p1_s2_r;

  logic                              p2_vld_r, p2_ok_r;
  logic signed [tlfk_pkg::PROD_W-1:0] p2_c1_nxt, p2_s1_nxt, p2_c2_nxt, p2_s2_nxt;
  logic signed [tlfk_pkg::PROD_W-1:0] p2_c1_r, p2_s1_r, p2_c2_r, p2_s2_r;

  logic signed [tlfk_pkg::PROD_W-1:0] rc1_w, rs1_w, rc2_w, rs2_w;
  logic                              p3_vld_r, p3_ok_r;
  logic signed [tlfk_pkg::ELB_W-1:0] p3_ex_r, p3_ey_r;
  logic signed [tlfk_pkg::SCL_W-1:0] p3_dx_r, p3_dy_r;

  logic signed [tlfk_pkg::END_W-1:0] ex_w, ey_w, fx_w, fy_w;
  logic                              vld_r, ok_r;
  logic [tlfk_pkg::POS_W-1:0]        elbow_x_r, elbow_y_r, end_x_r, end_y_r;

  // Stage one: undo the fold by negating both results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= ctl.vld;
    end
    p1_ok_r <= ctl.ok;
    p1_c1_r <= ctl.neg_a ? -lane_a.x : lane_a.x;
    p1_s1_r <= ctl.neg_a ? -lane_a.y : lane_a.y;
    p1_c2_r <= ctl.neg_b ? -lane_b.x : lane_b.x;
    p1_s2_r <= ctl.neg_b ? -lane_b.y : lane_b.y;
  end

  // Stage two: link length times cosine and sine.
  assign p2_c1_nxt = $signed({1'b0, link1_length}) * p1_c1_r;
  assign p2_s1_nxt = $signed({1'b0, link1_length}) * p1_s1_r;
  assign p2_c2_nxt = $signed({1'b0, link2_length}) * p1_c2_r;
  assign p2_s2_nxt = $signed({1'b0, link2_length}) * p1_s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else begin
      p2_vld_r <= p1_vld_r;
    end
    p2_ok_r <= p1_ok_r;
    p2_c1_r <= p2_c1_nxt;
    p2_s1_r <= p2_s1_nxt;
    p2_c2_r <= p2_c2_nxt;
    p2_s2_r <= p2_s2_nxt;
  end

  // Stage three: round half up to Q16.16 and place the elbow.
  assign rc1_w = p2_c1_r + tlfk_pkg::ROUND_HALF;
  assign rs1_w = p2_s1_r + tlfk_pkg::ROUND_HALF;
  assign rc2_w = p2_c2_r + tlfk_pkg::ROUND_HALF;
  assign rs2_w = p2_s2_r + tlfk_pkg::ROUND_HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else begin
      p3_vld_r <= p2_vld_r;
    end
    p3_ok_r <= p2_ok_r;
    p3_ex_r <= {{4{origin_x[tlfk_pkg::POS_W-1]}}, origin_x}
             + {rc1_w[64], rc1_w[64:30]};
    p3_ey_r <= {{4{origin_y[tlfk_pkg::POS_W-1]}}, origin_y}
             + {rs1_w[64], rs1_w[64:30]};
    p3_dx_r <= rc2_w[64:30];
    p3_dy_r <= rs2_w[64:30];
  end

  // Stage four: end point on the unsaturated elbow, then clamp; a rejected configuration gives zeros.
  assign ex_w = {p3_ex_r[tlfk_pkg::ELB_W-1], p3_ex_r};
  assign ey_w = {p3_ey_r[tlfk_pkg::ELB_W-1], p3_ey_r};
  assign fx_w = ex_w + {{2{p3_dx_r[tlfk_pkg::SCL_W-1]}}, p3_dx_r};
  assign fy_w = ey_w + {{2{p3_dy_r[tlfk_pkg::SCL_W-1]}}, p3_dy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= p3_vld_r;
    end
    ok_r      <= p3_ok_r;
    elbow_x_r <= p3_ok_r ? tlfk_pkg::sat32(ex_w) : '0;
    elbow_y_r <= p3_ok_r ? tlfk_pkg::sat32(ey_w) : '0;
    end_x_r   <= p3_ok_r ? tlfk_pkg::sat32(fx_w) : '0;
    end_y_r   <= p3_ok_r ? tlfk_pkg::sat32(fy_w) : '0;
  end

  assign res_vld    = vld_r;
  assign pose_valid = ok_r;
  assign elbow_x    = elbow_x_r;
  assign elbow_y    = elbow_y_r;
  assign end_x      = end_x_r;
  assign end_y      = end_y_r;

endmodule

// ===== rtl/two_link_forward_kinematics_unit.sv =====
`timescale 1ns / 1ps
// Planar two-link arm forward kinematics. A request is taken on every cycle
// that start is high (busy stays low), and its pose appears as a one-cycle
// out_valid strobe after angle reduction, one registered rotation stage per
// CORDIC iteration (STEPS, which is ROTATION_STEPS capped at 24), and
// scaling, offset and clamping. The receiver cannot stall, so a result must
// be captured in the cycle it is shown. Configuration writes take effect at
// once and belong to quiet periods with nothing in flight.
module two_link_forward_kinematics_unit #(
  parameter int ROTATION_STEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [tlfk_pkg::ANG_W-1:0] in_angle_one,
  input  logic signed [tlfk_pkg::ANG_W-1:0] in_angle_two,
  input  logic                              cfg_we,
  input  logic [tlfk_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [tlfk_pkg::CFG_W-1:0]        cfg_wdata,
  output logic                              out_valid,
  output logic signed [tlfk_pkg::POS_W-1:0] out_elbow_x,
  output logic signed [tlfk_pkg::POS_W-1:0] out_elbow_y,
  output logic signed [tlfk_pkg::POS_W-1:0] out_end_x,
  output logic signed [tlfk_pkg::POS_W-1:0] out_end_y,
  output logic                              out_pose_valid
);

  localparam int STEPS = (ROTATION_STEPS > tlfk_pkg::MAX_STEPS) ?
                         tlfk_pkg::MAX_STEPS : ROTATION_STEPS;

  logic [tlfk_pkg::LEN_W-1:0]        link1_length_r, link2_length_r;
  logic signed [tlfk_pkg::POS_W-1:0] origin_x_r, origin_y_r;
  logic signed [tlfk_pkg::ANG_W-1:0] joint1_min_r, joint1_max_r;
  logic signed [tlfk_pkg::ANG_W-1:0] joint2_min_r, joint2_max_r;
  logic                              cfg_ok;
  logic                              req_vld;

  tlfk_pkg::ctl_t rd_ctl, rot_ctl;
  tlfk_pkg::rot_t rd_a, rd_b, rot_a, rot_b;

  logic [tlfk_pkg::POS_W-1:0] elbow_x, elbow_y, end_x, end_y;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link1_length_r <= 31'd65536;
      link2_length_r <= 31'd65536;
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      joint1_min_r   <= -20'sd102944;
      joint1_max_r   <= 20'sd102944;
      joint2_min_r   <= -20'sd102944;
      joint2_max_r   <= 20'sd102944;
    end else if (cfg_we) begin
      case (tlfk_pkg::cfg_idx_t'(cfg_index))
        tlfk_pkg::REG_LINK1_LENGTH: link1_length_r <= cfg_wdata[tlfk_pkg::LEN_W-1:0];
        tlfk_pkg::REG_LINK2_LENGTH: link2_length_r <= cfg_wdata[tlfk_pkg::LEN_W-1:0];
        tlfk_pkg::REG_ORIGIN_X:     origin_x_r     <= cfg_wdata;
        tlfk_pkg::REG_ORIGIN_Y:     origin_y_r     <= cfg_wdata;
        tlfk_pkg::REG_JOINT1_MIN:   joint1_min_r   <= cfg_wdata[tlfk_pkg::ANG_W-1:0];
        tlfk_pkg::REG_JOINT1_MAX:   joint1_max_r   <= cfg_wdata[tlfk_pkg::ANG_W-1:0];
        tlfk_pkg::REG_JOINT2_MIN:   joint2_min_r   <= cfg_wdata[tlfk_pkg::ANG_W-1:0];
        tlfk_pkg::REG_JOINT2_MAX:   joint2_max_r   <= cfg_wdata[tlfk_pkg::ANG_W-1:0];
        default: ;
      endcase
    end
  end

  // The configuration is usable when both links have length and limits are ordered.
  assign cfg_ok = (link1_length_r != '0) && (link2_length_r != '0) &&
                  (joint1_max_r >= joint1_min_r) && (joint2_max_r >= joint2_min_r);

  assign busy    = 1'b0;
  assign req_vld = start && !busy;

  tlfk_angle_reduce u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_vld   (req_vld),
    .cfg_ok    (cfg_ok),
    .angle_one (in_angle_one),
    .angle_two (in_angle_two),
    .ctl       (rd_ctl),
    .lane_a    (rd_a),
    .lane_b    (rd_b)
  );

  tlfk_cordic #(
    .STEPS (STEPS)
  ) u_cordic (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_in     (rd_ctl),
    .lane_a_in  (rd_a),
    .lane_b_in  (rd_b),
    .ctl_out    (rot_ctl),
    .lane_a_out (rot_a),
    .lane_b_out (rot_b)
  );

  tlfk_position u_position (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (rot_ctl),
    .lane_a       (rot_a),
    .lane_b       (rot_b),
    .link1_length (link1_length_r),
    .link2_length (link2_length_r),
    .origin_x     (origin_x_r),
    .origin_y     (origin_y_r),
    .res_vld      (out_valid),
    .elbow_x      (elbow_x),
    .elbow_y      (elbow_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .pose_valid   (out_pose_valid)
  );

  assign out_elbow_x = $signed(elbow_x);
  assign out_elbow_y = $signed(elbow_y);
  assign out_end_x   = $signed(end_x);
  assign out_end_y   = $signed(end_y);

endmodule

// ===== rtl/tlfk_checker.sv =====
`timescale 1ns / 1ps
module tlfk_checker #(
  parameter int ROTATION_STEPS = 16
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic signed [tlfk_pkg::POS_W-1:0] out_elbow_x,
  input logic signed [tlfk_pkg::POS_W-1:0] out_elbow_y,
  input logic signed [tlfk_pkg::POS_W-1:0] out_end_x,
  input logic signed [tlfk_pkg::POS_W-1:0] out_end_y,
  input logic                              out_pose_valid
);

  localparam int STEPS   = (ROTATION_STEPS > tlfk_pkg::MAX_STEPS) ?
                           tlfk_pkg::MAX_STEPS : ROTATION_STEPS;
  localparam int LATENCY = tlfk_pkg::REDUCE_STAGES + STEPS + tlfk_pkg::POSITION_STAGES;

  // Reset empties the pipeline.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  // Every accepted request produces its result once it has passed the reduction, rotation and position stages.
  a_req_to_res: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result missing after request");

  // No result appears without a request that has passed the reduction, rotation and position stages.
  a_res_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without request");

  // A rejected configuration gives an all-zero pose.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_pose_valid) |->
      (out_elbow_x == '0 && out_elbow_y == '0 && out_end_x == '0 && out_end_y == '0))
    else $error("nonzero pose on invalid configuration");

endmodule

bind two_link_forward_kinematics_unit tlfk_checker #(
  .ROTATION_STEPS (ROTATION_STEPS)
) u_tlfk_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_elbow_x    (out_elbow_x),
  .out_elbow_y    (out_elbow_y),
  .out_end_x      (out_end_x),
  .out_end_y      (out_end_y),
  .out_pose_valid (out_pose_valid)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  localparam int  ANG_W      = tlfk_pkg::ANG_W;
  localparam int  POS_W      = tlfk_pkg::POS_W;
  localparam int  CFG_IW     = tlfk_pkg::CFG_IW;
  localparam int  CFG_W      = tlfk_pkg::CFG_W;
  localparam int  STEPS      = 16;
  localparam int  LATENCY    = STEPS + 7;
  localparam int  STALL_MAX  = 4000;
  localparam longint TURN_Q30 = 64'sd6746518852;
  localparam longint PI_Q30   = 64'sd3373259426;
  localparam longint HPI_Q30  = 64'sd1686629713;
  localparam longint GAIN_Q30 = 64'sd652032874;

  // One pose as the block reports it.
  typedef struct packed {
    logic [31:0] elbow_x;
    logic [31:0] elbow_y;
    logic [31:0] end_x;
    logic [31:0] end_y;
    logic        ok;
  } pose_t;

  // Holds the poses still owed by the block, oldest first.
  class pose_scoreboard;
    pose_t owed[$];
    int    errors;
    int    checked;

    function void note(pose_t p);
      owed.push_back(p);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("ERROR at %0t: %s got %h, want %h", $realtime, what, got, want);
      errors++;
    endtask

    task check(pose_t got);
      pose_t want;
      if (owed.size() == 0) begin
        report("pose with none outstanding", got.elbow_x, 32'h0);
      end else begin
        want = owed.pop_front();
        checked++;
        if (got.elbow_x !== want.elbow_x) report("elbow_x", got.elbow_x, want.elbow_x);
        if (got.elbow_y !== want.elbow_y) report("elbow_y", got.elbow_y, want.elbow_y);
        if (got.end_x !== want.end_x) report("end_x", got.end_x, want.end_x);
        if (got.end_y !== want.end_y) report("end_y", got.end_y, want.end_y);
        if (got.ok !== want.ok) report("pose_valid", got.ok, want.ok);
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic signed [ANG_W-1:0] in_angle_one = '0;
  logic signed [ANG_W-1:0] in_angle_two = '0;
  logic        cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic        out_valid;
  logic signed [POS_W-1:0] out_elbow_x, out_elbow_y, out_end_x, out_end_y;
  logic        out_pose_valid;

  two_link_forward_kinematics_unit #(.ROTATION_STEPS(STEPS)) i_dut (
    .clk, .rst_n, .start, .busy, .in_angle_one, .in_angle_two,
    .cfg_we, .cfg_index, .cfg_wdata, .out_valid, .out_elbow_x, .out_elbow_y,
    .out_end_x, .out_end_y, .out_pose_valid
  );

  always #5 clk = ~clk;

  // Shadow copy of the arm geometry.
  longint len1 = 65536, len2 = 65536, base_x = 0, base_y = 0;
  longint j1_lo = -102944, j1_hi = 102944, j2_lo = -102944, j2_hi = 102944;

  longint atan_tab[24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  pose_scoreboard sb = new();
  int sent;
  int invalid_sent;
  int idle_pct;
  int quiet_cycles = 0;

  // Cosine and sine in Q30 of a Q16 angle by reduction, folding and rotation.
  function automatic void sin_cos(input longint ang, output longint c, output longint s);
    longint r, x, y, dx, dy;
    bit     flip;
    r = (ang * 16384) % TURN_Q30;
    flip = 1'b0;
    x = GAIN_Q30;
    y = 0;
    if (r >= PI_Q30) r -= TURN_Q30;
    if (r < -PI_Q30) r += TURN_Q30;
    if (r > HPI_Q30) begin
      r -= PI_Q30;
      flip = 1'b1;
    end else if (r < -HPI_Q30) begin
      r += PI_Q30;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (r >= 0) begin
        x -= dx; y += dy; r -= atan_tab[i];
      end else begin
        x += dx; y -= dy; r += atan_tab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint scale_len(longint len, longint t);
    return (len * t + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Expected pose for one pair of joint angles under the current geometry.
  function automatic pose_t arm_pose(logic signed [ANG_W-1:0] a1, logic signed [ANG_W-1:0] a2);
    pose_t  p;
    longint c1, s1, c2, s2, ex, ey;
    p = '0;
    if (len1 > 0 && len2 > 0 && j1_hi >= j1_lo && j2_hi >= j2_lo) begin
      sin_cos(longint'(a1), c1, s1);
      sin_cos(longint'(a1) + longint'(a2), c2, s2);
      ex = base_x + scale_len(len1, c1);
      ey = base_y + scale_len(len1, s1);
      p.elbow_x = clamp32(ex);
      p.elbow_y = clamp32(ey);
      p.end_x = clamp32(ex + scale_len(len2, c2));
      p.end_y = clamp32(ey + scale_len(len2, s2));
      p.ok = 1'b1;
    end
    return p;
  endfunction

  // Capture every pose strobe.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check({out_elbow_x, out_elbow_y, out_end_x, out_end_y, out_pose_valid});
    end
  end

  // Watchdog on cycles with no request and no pose moving.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Issue one request, with random idle cycles ahead of it.
  task send(logic signed [ANG_W-1:0] a1, logic signed [ANG_W-1:0] a2);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_angle_one <= a1;
    in_angle_two <= a2;
    do @(posedge clk); while (busy);
    sb.note(arm_pose(a1, a2));
    sent++;
    if (!(len1 > 0 && len2 > 0 && j1_hi >= j1_lo && j2_hi >= j2_lo)) invalid_sent++;
  endtask

  task send_random();
    send(ANG_W'($urandom), ANG_W'($urandom));
  endtask

  // Stop sending and let every outstanding pose come back.
  task drain();
    start <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Write all eight registers while the pipeline is empty.
  task set_geometry(longint l1, longint l2, longint ox, longint oy,
                    longint m1, longint x1, longint m2, longint x2);
    logic [31:0] vals[8];
    vals = '{l1[31:0], l2[31:0], ox[31:0], oy[31:0], m1[31:0], x1[31:0], m2[31:0], x2[31:0]};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= tlfk_pkg::cfg_idx_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    len1 = vals[tlfk_pkg::REG_LINK1_LENGTH] & 32'h7FFF_FFFF;
    len2 = vals[tlfk_pkg::REG_LINK2_LENGTH] & 32'h7FFF_FFFF;
    base_x = longint'(signed'(vals[tlfk_pkg::REG_ORIGIN_X]));
    base_y = longint'(signed'(vals[tlfk_pkg::REG_ORIGIN_Y]));
    j1_lo = longint'(signed'(vals[tlfk_pkg::REG_JOINT1_MIN][ANG_W-1:0]));
    j1_hi = longint'(signed'(vals[tlfk_pkg::REG_JOINT1_MAX][ANG_W-1:0]));
    j2_lo = longint'(signed'(vals[tlfk_pkg::REG_JOINT2_MIN][ANG_W-1:0]));
    j2_hi = longint'(signed'(vals[tlfk_pkg::REG_JOINT2_MAX][ANG_W-1:0]));
  endtask

  function automatic longint rand_len();
    case ($urandom_range(3))
      0: return $urandom_range(1, 255);
      1: return $urandom & 32'h7FFF_FFFF;
      default: return $urandom_range(1, 32'h00FF_FFFF);
    endcase
  endfunction

  function automatic longint rand_pos();
    if ($urandom_range(2) == 0) return longint'(signed'(32'($urandom)));
    return longint'($urandom_range(0, 32'h01FF_FFFF)) - 64'sd16777216;
  endfunction

  function automatic longint rand_ang();
    return longint'(signed'(ANG_W'($urandom)));
  endfunction

  initial begin
    longint lo, hi;
    int     phase;
    idle_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed angles under the reset geometry: extremes, half and quarter turns.
    idle_pct = 36;
    send(-20'sd524288, -20'sd524288);
    send(20'sd524287, 20'sd524287);
    send(20'sd0, 20'sd0);
    send(20'sd205887, 20'sd0);
    send(-20'sd205887, 20'sd0);
    send(20'sd205888, -20'sd411775);
    send(20'sd102944, 20'sd102944);
    send(-20'sd102944, -20'sd102943);
    send(20'sd411775, 20'sd1);
    send(20'sd524287, -20'sd524288);
    drain();

    // Saturation with the longest links and the base at two opposite corners.
    set_geometry(64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF,
                 -524288, 524287, -524288, 524287);
    send(20'sd0, 20'sd0);
    send(20'sd102944, 20'sd0);
    drain();
    set_geometry(64'h7FFF_FFFF, 64'h7FFF_FFFF, -64'sd2147483648, -64'sd2147483648,
                 524287, 524287, -524288, -524288);
    send(20'sd205887, 20'sd0);
    send(-20'sd102944, 20'sd0);
    drain();

    // Inconsistent geometry: zero links and inverted joint ranges.
    set_geometry(0, 65536, 0, 0, -102944, 102944, -102944, 102944);
    send(20'sd1000, 20'sd2000);
    drain();
    set_geometry(65536, 0, 0, 0, -102944, 102944, -102944, 102944);
    send(20'sd1000, 20'sd2000);
    drain();
    set_geometry(65536, 65536, 0, 0, 524287, -524288, -102944, 102944);
    send(20'sd1000, 20'sd2000);
    drain();
    set_geometry(65536, 65536, 0, 0, -102944, 102944, 1, 0);
    send(20'sd1000, 20'sd2000);
    drain();

    // Random phases, each under fresh geometry, with three idling regimes.
    for (phase = 0; phase < 11; phase++) begin
      idle_pct = (phase < 4) ? 36 : (phase < 8) ? 62 : 0;
      lo = rand_ang();
      hi = rand_ang();
      if (lo > hi && $urandom_range(9) != 0) begin
        longint t;
        t = lo; lo = hi; hi = t;
      end
      set_geometry(rand_len(), rand_len(), rand_pos(), rand_pos(),
                   lo, hi, -102944 - $urandom_range(1000), 102944 + $urandom_range(1000));
      repeat (150) send_random();
      drain();
    end

    $display("Sent %0d requests (%0d under inconsistent geometry), checked %0d poses.",
             sent, invalid_sent, sb.checked);
    $display("Covered angle extremes, wraparound, saturation and three idling regimes.");
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tlfk_pkg.sv
rtl/tlfk_angle_reduce.sv
rtl/tlfk_cordic.sv
rtl/tlfk_position.sv
rtl/two_link_forward_kinematics_unit.sv
rtl/tlfk_checker.sv
dv/testbench.sv
